### rtl/acfm_pkg.sv
// Shared types, constants and derived widths for the ADC frame averaging monitor.
// Depends on nothing; every other file of the block imports it.

package acfm_pkg;

   // Frame shape.
   localparam int GROUPS      = 10;
   localparam int SAMPLE_BITS = 12;
   localparam int CH_COUNT    = 6;
   localparam int CH_W        = 3;

   // Field widths of the ports.
   localparam int SAMPLE_W = 12;
   localparam int AVG_W    = 12;
   localparam int MV_W     = 13;
   localparam int DERIV_W  = 18;
   localparam int REF_W    = 13;
   localparam int RANGE_W  = 6;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam logic [CSR_IDX_W-1:0] REG_REF_MV       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HALL_MOTOR   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HALL_BATTERY = 2'd2;
   localparam logic [REF_W-1:0]   REF_MV_RESET       = 13'd3300;
   localparam logic [RANGE_W-1:0] HALL_MOTOR_RESET   = 6'd5;
   localparam logic [RANGE_W-1:0] HALL_BATTERY_RESET = 6'd20;

   // Channel roles.
   localparam logic [CH_W-1:0] CH_MOTOR_A  = 3'd0;
   localparam logic [CH_W-1:0] CH_SHUNT_A  = 3'd1;
   localparam logic [CH_W-1:0] CH_BATT_V   = 3'd2;
   localparam logic [CH_W-1:0] CH_BATT_I   = 3'd3;
   localparam logic [CH_W-1:0] CH_SHUNT_B  = 3'd4;
   localparam logic [CH_W-1:0] CH_MOTOR_B  = 3'd5;
   localparam logic [CH_W-1:0] CH_LAST     = CH_MOTOR_B;

   // Running sums and the group counter.
   localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
   localparam int SUM_W      = $clog2(GROUPS * SAMPLE_MAX + 1);
   localparam int GRP_W      = $clog2(GROUPS + 1);

   // Division of a sum by GROUPS: multiply by a rounded-up reciprocal and shift.
   localparam int          G_SH      = SUM_W + $clog2(GROUPS);
   localparam int          G_RECIP_W = SUM_W + 1;
   localparam logic [63:0] G_RECIP   = ((64'd1 << G_SH) + GROUPS - 1) / GROUPS;
   localparam int          GPROD_W   = SUM_W + G_RECIP_W;

   // Scaling to millivolts: average * ref_mv / FULL_SCALE.
   localparam int          FULL_SCALE = (1 << SAMPLE_BITS) - 1;
   localparam int          V_W        = AVG_W + REF_W;
   localparam int          F_SH       = V_W + $clog2(FULL_SCALE);
   localparam int          F_RECIP_W  = V_W + 1;
   localparam logic [63:0] F_RECIP    = ((64'd1 << F_SH) + FULL_SCALE - 1) / FULL_SCALE;
   localparam int          VPROD_W    = V_W + F_RECIP_W;
   localparam int          VOLT_MAX   = 8191;

   // Derived quantities. 1000/1650 reduces to 20/33 and 1000/585 to 200/117.
   localparam int HALL_MID_MV  = 1650;
   localparam int HALL_SCALE   = 20;
   localparam int HALL_DIV     = 33;
   localparam int SHUNT_SCALE  = 200;
   localparam int SHUNT_DIV    = 117;
   localparam int BATT_SCALE   = 11;
   localparam int RNGS_W       = 11;
   localparam int NUM_W        = 26;
   localparam int MAG_W        = NUM_W - 1;
   localparam int DIV_SH       = 31;
   localparam int DIV_RECIP_W  = 26;
   localparam logic [63:0] HALL_RECIP  = ((64'd1 << DIV_SH) + HALL_DIV - 1) / HALL_DIV;
   localparam logic [63:0] SHUNT_RECIP = ((64'd1 << DIV_SH) + SHUNT_DIV - 1) / SHUNT_DIV;
   localparam int DPROD_W      = MAG_W + DIV_RECIP_W;
   localparam int DERIV_MAX    = 131071;
   localparam int DERIV_MIN    = -131072;

   // Queue between the accumulator and the converter.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One finished channel sum on its way to the converter.
   typedef struct packed {
      logic [CH_W-1:0]  channel;
      logic [SUM_W-1:0] sum;
      logic             last;
   } queue_item_type;

   // Configuration as seen by the converter.
   typedef struct packed {
      logic [REF_W-1:0]   ref_mv;
      logic [RANGE_W-1:0] hall_range_motor;
      logic [RANGE_W-1:0] hall_range_battery;
   } cfg_type;

endpackage

### rtl/acfm_if.sv
// Valid/ready channel interfaces for samples in and results out.
// Depends on acfm_pkg for the field widths.

interface acfm_req_if import acfm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface acfm_rsp_if import acfm_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CH_W-1:0]           channel;
   logic [AVG_W-1:0]          average_raw;
   logic [MV_W-1:0]           voltage_mv;
   logic signed [DERIV_W-1:0] derived_value;
   logic                      last;

   modport source (output valid, output channel, output average_raw, output voltage_mv,
                   output derived_value, output last, input ready);
   modport sink   (input valid, input channel, input average_raw, input voltage_mv,
                   input derived_value, input last, output ready);
endinterface

### rtl/acfm_front.sv
// Front end: accepts interleaved samples, keeps one running sum per channel and,
// at the end of a frame, hands the six sums to the queue. Depends on acfm_pkg, acfm_if.

module acfm_front import acfm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   acfm_req_if.sink       req_bus,
   output logic           push_valid,
   input  logic           push_ready,
   output queue_item_type push_item
);

   logic [SUM_W-1:0] sums_ff [CH_COUNT];
   logic [CH_W-1:0]  pos_ff, pos_in;
   logic [GRP_W-1:0] grp_ff, grp_in;
   logic             drain_ff, drain_in;
   logic             sum_wr;
   logic [SUM_W-1:0] sum_in;
   logic             accept;

   // Samples are refused only while a finished frame is being drained.
   assign req_bus.ready = !drain_ff;
   assign accept        = req_bus.valid && !drain_ff;

   // The drain walks the channels with the same position counter.
   assign push_valid        = drain_ff;
   assign push_item.channel = pos_ff;
   assign push_item.sum     = sums_ff[pos_ff];
   assign push_item.last    = (pos_ff == CH_LAST);

   // Position, group and drain control.
   always_comb begin
      pos_in   = pos_ff;
      grp_in   = grp_ff;
      drain_in = drain_ff;
      sum_wr   = 1'b0;
      sum_in   = '0;
      if (accept) begin
         sum_wr = 1'b1;
         sum_in = sums_ff[pos_ff] + SUM_W'(req_bus.sample);
         if (pos_ff == CH_LAST) begin
            pos_in = '0;
            if (grp_ff == GRP_W'(GROUPS - 1)) begin
               grp_in   = '0;
               drain_in = 1'b1;
            end else begin
               grp_in = grp_ff + 1'b1;
            end
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end else if (drain_ff && push_ready) begin
         // A sum leaves for the queue and is cleared for the next frame.
         sum_wr = 1'b1;
         sum_in = '0;
         if (pos_ff == CH_LAST) begin
            pos_in   = '0;
            drain_in = 1'b0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         grp_ff   <= '0;
         drain_ff <= 1'b0;
         for (int i = 0; i < CH_COUNT; i++) begin
            sums_ff[i] <= '0;
         end
      end else begin
         pos_ff   <= pos_in;
         grp_ff   <= grp_in;
         drain_ff <= drain_in;
         if (sum_wr) begin
            sums_ff[pos_ff] <= sum_in;
         end
      end
   end

endmodule

### rtl/acfm_queue.sv
// Short first-in first-out queue of channel sums between front end and converter.
// Depends on acfm_pkg.

module acfm_queue import acfm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   output logic           push_ready,
   input  queue_item_type push_item,
   output logic           pop_valid,
   input  logic           pop_ready,
   output queue_item_type pop_item
);

   queue_item_type    slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer wrap and occupancy.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/acfm_back.sv
// Back end: turns one channel sum into average, millivolts and derived value with a
// multiply-per-step sequencer, and holds the result for the sink. Depends on acfm_pkg, acfm_if.

module acfm_back import acfm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  logic           pop_valid,
   output logic           pop_ready,
   input  queue_item_type pop_item,
   acfm_rsp_if.source     rsp_bus
);

   // Sequencer steps.
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_AVG   = 3'd1;
   localparam logic [2:0] ST_SCALE = 3'd2;
   localparam logic [2:0] ST_VDIV  = 3'd3;
   localparam logic [2:0] ST_VSAT  = 3'd4;
   localparam logic [2:0] ST_NUM   = 3'd5;
   localparam logic [2:0] ST_DIV   = 3'd6;
   localparam logic [2:0] ST_OUT   = 3'd7;

   logic [2:0]                state_ff, state_in;
   logic                      out_valid_ff, out_valid_in;

   logic [CH_W-1:0]           item_ch_ff;
   logic                      item_last_ff;
   logic [GPROD_W-1:0]        gprod_ff, gprod_in;
   logic [AVG_W-1:0]          avg_ff, avg_in;
   logic [V_W-1:0]            volt_ff, volt_in;
   logic [VPROD_W-1:0]        vprod_ff, vprod_in;
   logic [MV_W-1:0]           mv_ff, mv_in;
   logic signed [NUM_W-1:0]   num_ff, num_in;
   logic [DIV_RECIP_W-1:0]    recip_ff, recip_in;
   logic                      bypass_ff, bypass_in;
   logic [MAG_W-1:0]          mag_ff, mag_in;
   logic                      neg_ff, neg_in;
   logic [DPROD_W-1:0]        dprod_ff, dprod_in;

   logic [CH_W-1:0]           rsp_ch_ff;
   logic [AVG_W-1:0]          rsp_avg_ff;
   logic [MV_W-1:0]           rsp_mv_ff;
   logic signed [DERIV_W-1:0] rsp_deriv_ff, rsp_deriv_in;
   logic                      rsp_last_ff;

   logic                      take, load;
   logic [31:0]               vquot;
   logic signed [NUM_W-1:0]   diff_x, rng_x, neg_num;
   logic [RNGS_W-1:0]         rng_scaled;
   logic [RANGE_W-1:0]        rng_sel;
   logic [31:0]               quot;
   logic signed [32:0]        mag_val, sval;

   assign pop_ready = (state_ff == ST_IDLE);
   assign take      = pop_valid && pop_ready;
   assign load      = (state_ff == ST_OUT) && (!out_valid_ff || rsp_bus.ready);

   // Step sequencing; the last step waits for room in the output register.
   always_comb begin
      case (state_ff)
         ST_IDLE:  state_in = take ? ST_AVG : ST_IDLE;
         ST_AVG:   state_in = ST_SCALE;
         ST_SCALE: state_in = ST_VDIV;
         ST_VDIV:  state_in = ST_VSAT;
         ST_VSAT:  state_in = ST_NUM;
         ST_NUM:   state_in = ST_DIV;
         ST_DIV:   state_in = ST_OUT;
         ST_OUT:   state_in = load ? ST_IDLE : ST_OUT;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Average and voltage chain: one multiplication per step.
   always_comb begin
      gprod_in = GPROD_W'(pop_item.sum) * GPROD_W'(G_RECIP[G_RECIP_W-1:0]);
      avg_in   = AVG_W'(gprod_ff >> G_SH);
      volt_in  = V_W'(avg_ff) * V_W'(cfg.ref_mv);
      vprod_in = VPROD_W'(volt_ff) * VPROD_W'(F_RECIP[F_RECIP_W-1:0]);
      vquot    = 32'(vprod_ff >> F_SH);
      mv_in    = (vquot > 32'(VOLT_MAX)) ? MV_W'(VOLT_MAX) : MV_W'(vquot);
   end

   // Numerator and divisor of the derived value, chosen by the channel role.
   always_comb begin
      rng_sel    = (item_ch_ff == CH_BATT_I) ? cfg.hall_range_battery : cfg.hall_range_motor;
      rng_scaled = RNGS_W'(rng_sel) * RNGS_W'(HALL_SCALE);
      diff_x     = $signed(NUM_W'(mv_ff)) - $signed(NUM_W'(HALL_MID_MV));
      rng_x      = $signed(NUM_W'(rng_scaled));
      case (item_ch_ff)
         CH_MOTOR_A, CH_MOTOR_B, CH_BATT_I: begin
            num_in    = diff_x * rng_x;
            recip_in  = HALL_RECIP[DIV_RECIP_W-1:0];
            bypass_in = 1'b0;
         end
         CH_SHUNT_A, CH_SHUNT_B: begin
            num_in    = $signed(NUM_W'(mv_ff) * NUM_W'(SHUNT_SCALE));
            recip_in  = SHUNT_RECIP[DIV_RECIP_W-1:0];
            bypass_in = 1'b0;
         end
         default: begin
            // Battery voltage needs no division.
            num_in    = $signed(NUM_W'(mv_ff) * NUM_W'(BATT_SCALE));
            recip_in  = SHUNT_RECIP[DIV_RECIP_W-1:0];
            bypass_in = 1'b1;
         end
      endcase
   end

   // Division of the magnitude truncates toward zero; the sign goes back on after.
   always_comb begin
      neg_num  = -num_ff;
      neg_in   = num_ff[NUM_W-1];
      mag_in   = MAG_W'(neg_in ? neg_num : num_ff);
      dprod_in = DPROD_W'(mag_in) * DPROD_W'(recip_ff);
      quot     = bypass_ff ? 32'(mag_ff) : 32'(dprod_ff >> DIV_SH);
      mag_val  = $signed({1'b0, quot});
      sval     = neg_ff ? -mag_val : mag_val;
      if (sval > 33'(DERIV_MAX)) begin
         rsp_deriv_in = DERIV_W'(DERIV_MAX);
      end else if (sval < 33'(DERIV_MIN)) begin
         rsp_deriv_in = DERIV_W'(DERIV_MIN);
      end else begin
         rsp_deriv_in = DERIV_W'(sval);
      end
   end

   // The output register stays full until the sink takes the transaction.
   assign out_valid_in = load ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath registers, each written in its own step.
   always_ff @(posedge clock) begin
      if (take) begin
         item_ch_ff   <= pop_item.channel;
         item_last_ff <= pop_item.last;
         gprod_ff     <= gprod_in;
      end
      if (state_ff == ST_AVG) begin
         avg_ff <= avg_in;
      end
      if (state_ff == ST_SCALE) begin
         volt_ff <= volt_in;
      end
      if (state_ff == ST_VDIV) begin
         vprod_ff <= vprod_in;
      end
      if (state_ff == ST_VSAT) begin
         mv_ff <= mv_in;
      end
      if (state_ff == ST_NUM) begin
         num_ff    <= num_in;
         recip_ff  <= recip_in;
         bypass_ff <= bypass_in;
      end
      if (state_ff == ST_DIV) begin
         mag_ff   <= mag_in;
         neg_ff   <= neg_in;
         dprod_ff <= dprod_in;
      end
      if (load) begin
         rsp_ch_ff    <= item_ch_ff;
         rsp_avg_ff   <= avg_ff;
         rsp_mv_ff    <= mv_ff;
         rsp_deriv_ff <= rsp_deriv_in;
         rsp_last_ff  <= item_last_ff;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.channel       = rsp_ch_ff;
   assign rsp_bus.average_raw   = rsp_avg_ff;
   assign rsp_bus.voltage_mv    = rsp_mv_ff;
   assign rsp_bus.derived_value = rsp_deriv_ff;
   assign rsp_bus.last          = rsp_last_ff;

endmodule

### rtl/adc_frame_average_current_monitor_unit.sv
// ADC frame averaging current monitor. Samples arrive on req_bus in channel order 0 to 5
// and are taken one per clock. After GROUPS complete groups, the six channel sums move
// through a two-entry queue and are cleared as they leave. req_bus.ready stays low for
// the whole of that move. The queue fills while the converter works, so the move holds
// the input while the converter frees queue slots, and longer when the result side stalls.
// A converter sequencer then turns each sum into one result through its steps AVG, SCALE,
// VDIV, VSAT, NUM, DIV and OUT, a chain of dependent multiplications, and takes no new sum
// until the last result is in its output register. Each result
// carries the truncated average, the voltage in millivolts (saturated at 8191) and a
// channel-specific current or battery voltage, saturated to 18 bits; the last flag marks
// channel 5. Registers are written through csr_we/csr_index/csr_wdata and must only
// change while no frame is in flight.
// Depends on acfm_pkg, acfm_if, acfm_front, acfm_queue and acfm_back.

module adc_frame_average_current_monitor_unit import acfm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   acfm_req_if.sink              req_bus,
   acfm_rsp_if.source            rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type        cfg_ff, cfg_in;
   logic           push_valid, push_ready;
   queue_item_type push_item;
   logic           pop_valid, pop_ready;
   queue_item_type pop_item;

   // Configuration registers; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_REF_MV:       cfg_in.ref_mv             = csr_wdata[REF_W-1:0];
            REG_HALL_MOTOR:   cfg_in.hall_range_motor   = csr_wdata[RANGE_W-1:0];
            REG_HALL_BATTERY: cfg_in.hall_range_battery = csr_wdata[RANGE_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ref_mv             <= REF_MV_RESET;
         cfg_ff.hall_range_motor   <= HALL_MOTOR_RESET;
         cfg_ff.hall_range_battery <= HALL_BATTERY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   acfm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   acfm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   acfm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_bus   (rsp_bus)
   );

   // The frame-ending flag belongs to channel 5 only.
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.last |-> rsp_bus.channel == CH_LAST)
      else $error("last flag on a result that is not channel 5");

   // Results never name a channel beyond the sixth.
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> rsp_bus.channel <= CH_LAST)
      else $error("result channel out of range");

   // Input stalls only right after a transaction that completed a frame.
   assert property (@(posedge clock) disable iff (reset)
      $fell(req_bus.ready) |-> $past(req_bus.valid && req_bus.ready))
      else $error("sample input stalled without a completed frame");

   // Every queued sum entering the converter carries its own channel's last flag.
   assert property (@(posedge clock) disable iff (reset)
      pop_valid |-> (pop_item.last == (pop_item.channel == CH_LAST)))
      else $error("queued item has inconsistent last flag");

endmodule

### tb/acfm_frame_checker.sv
// Watches the sample, result and register ports of the frame averaging monitor and
// predicts every channel report from its own copy of the sums and the registers.
// Depends on acfm_pkg and the channel interfaces in acfm_if.
`timescale 1ns / 100ps

module acfm_frame_checker import acfm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   acfm_req_if                   req_mon,
   acfm_rsp_if                   rsp_mon,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending_reports,
   output int                    reports_checked
);

   // Scale factors of the derived quantities.
   localparam longint MA_PER_A        = 1000;
   localparam longint SHUNT_UV_PER_MA = 585;
   localparam longint BATT_DIVIDER    = 11;
   localparam int     REPORT_LIMIT    = 10;

   typedef struct packed {
      logic [CH_W-1:0]           channel;
      logic [AVG_W-1:0]          average_raw;
      logic [MV_W-1:0]           voltage_mv;
      logic signed [DERIV_W-1:0] derived_value;
      logic                      last;
   } channel_report_type;

   channel_report_type outstanding_reports[$];
   longint unsigned    channel_sums[CH_COUNT];
   int                 next_channel;
   int                 groups_done;
   int                 mismatches;
   int                 checked;
   logic [REF_W-1:0]   ref_mv_cfg;
   logic [RANGE_W-1:0] hall_motor_cfg;
   logic [RANGE_W-1:0] hall_battery_cfg;

   // Hall sensor current in mA, centered on half the supply; truncates toward zero.
   function automatic longint hall_current(input longint millivolts,
                                           input logic [RANGE_W-1:0] range_amps);
      longint span;
      span = range_amps;
      return (millivolts - HALL_MID_MV) * span * MA_PER_A / HALL_MID_MV;
   endfunction

   // Converts one channel's frame sum into the report the block should send.
   function automatic channel_report_type convert_channel(input logic [CH_W-1:0] ch,
                                                          input longint sum);
      channel_report_type rep;
      longint average;
      longint ref_val;
      longint millivolts;
      longint derived;
      ref_val    = ref_mv_cfg;
      average    = sum / GROUPS;
      millivolts = average * ref_val / FULL_SCALE;
      if (millivolts > VOLT_MAX) millivolts = VOLT_MAX;
      case (ch)
         CH_MOTOR_A, CH_MOTOR_B: derived = hall_current(millivolts, hall_motor_cfg);
         CH_BATT_I:              derived = hall_current(millivolts, hall_battery_cfg);
         CH_SHUNT_A, CH_SHUNT_B: derived = millivolts * MA_PER_A / SHUNT_UV_PER_MA;
         default:                derived = millivolts * BATT_DIVIDER;
      endcase
      if (derived > DERIV_MAX) derived = DERIV_MAX;
      if (derived < DERIV_MIN) derived = DERIV_MIN;
      rep.channel       = ch;
      rep.average_raw   = average[AVG_W-1:0];
      rep.voltage_mv    = millivolts[MV_W-1:0];
      rep.derived_value = derived[DERIV_W-1:0];
      rep.last          = (ch == CH_LAST);
      return rep;
   endfunction

   // Adds one sample to its channel; a completed frame queues six reports.
   task automatic accumulate(input logic [SAMPLE_W-1:0] sample);
      channel_sums[next_channel] += sample;
      if (next_channel != CH_COUNT - 1) begin
         next_channel++;
      end else begin
         next_channel = 0;
         groups_done++;
         if (groups_done == GROUPS) begin
            for (int ch = 0; ch < CH_COUNT; ch++) begin
               outstanding_reports.push_back(convert_channel(CH_W'(ch), channel_sums[ch]));
               channel_sums[ch] = 0;
            end
            groups_done = 0;
         end
      end
   endtask

   // Compares one received report with the oldest outstanding one.
   task automatic compare_report();
      channel_report_type got;
      channel_report_type want;
      got.channel       = rsp_mon.channel;
      got.average_raw   = rsp_mon.average_raw;
      got.voltage_mv    = rsp_mon.voltage_mv;
      got.derived_value = rsp_mon.derived_value;
      got.last          = rsp_mon.last;
      checked++;
      if (outstanding_reports.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("unexpected report ch=%0d avg=%0d mv=%0d derived=%0d last=%0d",
                     got.channel, got.average_raw, got.voltage_mv,
                     got.derived_value, got.last);
      end else begin
         want = outstanding_reports.pop_front();
         if (got.channel !== want.channel || got.average_raw !== want.average_raw ||
             got.voltage_mv !== want.voltage_mv ||
             got.derived_value !== want.derived_value || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("report mismatch: expected ch=%0d avg=%0d mv=%0d derived=%0d last=%0d, %s",
                        want.channel, want.average_raw, want.voltage_mv,
                        want.derived_value, want.last,
                        $sformatf("got ch=%0d avg=%0d mv=%0d derived=%0d last=%0d",
                                  got.channel, got.average_raw, got.voltage_mv,
                                  got.derived_value, got.last));
         end
      end
   endtask

   // Every transaction and register write is taken at the rising edge.
   always @(posedge clock) begin
      if (reset) begin
         outstanding_reports.delete();
         foreach (channel_sums[ch]) channel_sums[ch] = 0;
         next_channel     = 0;
         groups_done      = 0;
         mismatches       = 0;
         checked          = 0;
         ref_mv_cfg       = REF_MV_RESET;
         hall_motor_cfg   = HALL_MOTOR_RESET;
         hall_battery_cfg = HALL_BATTERY_RESET;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_REF_MV:       ref_mv_cfg       = csr_wdata[REF_W-1:0];
               REG_HALL_MOTOR:   hall_motor_cfg   = csr_wdata[RANGE_W-1:0];
               REG_HALL_BATTERY: hall_battery_cfg = csr_wdata[RANGE_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) accumulate(req_mon.sample);
         if (rsp_mon.valid && rsp_mon.ready) compare_report();
      end
      fail_count      <= mismatches;
      pending_reports <= outstanding_reports.size();
      reports_checked <= checked;
   end

endmodule

### tb/tb_top.sv
// Top of the frame averaging monitor testbench: clock, reset, sample frames, register
// settings and random stalls on both channels. Depends on acfm_pkg, acfm_if, the
// block itself and acfm_frame_checker.
`timescale 1ns / 100ps

module tb_top;
   import acfm_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 64;
   localparam int CYCLE_LIMIT  = 200000;

   typedef enum {FRAME_ZERO, FRAME_FULL, FRAME_STAIR, FRAME_MIXED, FRAME_NEAR_MID} frame_kind_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    pending_reports;
   int                    reports_checked;
   int                    cycle_count;
   int                    samples_sent;
   int                    frames_sent;
   int                    settings_applied;
   bit                    tx_steady;
   bit                    rx_steady;
   logic [REF_W-1:0]      cur_ref;

   acfm_req_if req_bus ();
   acfm_rsp_if rsp_bus ();

   adc_frame_average_current_monitor_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   acfm_frame_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending_reports (pending_reports),
      .reports_checked (reports_checked)
   );

   // 12 ns clock.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Watchdog on the whole run.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL adc_frame_average_current_monitor_unit");
         $finish;
      end
   end

   // Result side: a random stall before each transaction, with runs of none.
   initial begin
      int wait_cycles;
      rsp_bus.ready <= 1'b0;
      rx_steady = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) rx_steady = !rx_steady;
         wait_cycles = rx_steady ? 0 : $urandom_range(0, 7);
         if (wait_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   // Offers one sample after a random gap and returns at its accepting edge.
   task automatic push_sample(input logic [SAMPLE_W-1:0] value);
      int gap;
      gap = tx_steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.sample <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      samples_sent++;
   endtask

   // Code that lands close to the hall midpoint under the current reference.
   function automatic logic [SAMPLE_W-1:0] near_mid_code();
      int code;
      code = (cur_ref == 0) ? 2048 : HALL_MID_MV * FULL_SCALE / cur_ref;
      code = code + $urandom_range(0, 40) - 20;
      if (code > SAMPLE_MAX) code = SAMPLE_MAX;
      if (code < 0) code = 0;
      return SAMPLE_W'(code);
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample(input frame_kind_type kind,
                                                       input int ch, input int grp);
      case (kind)
         FRAME_ZERO:     return '0;
         FRAME_FULL:     return SAMPLE_W'(SAMPLE_MAX);
         FRAME_STAIR:    return SAMPLE_W'(ch * 700 + grp * 37 + 3);
         FRAME_NEAR_MID: return near_mid_code();
         default: begin
            case ($urandom_range(0, 5))
               0:       return '0;
               1:       return SAMPLE_W'(SAMPLE_MAX);
               2:       return near_mid_code();
               default: return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
            endcase
         end
      endcase
   endfunction

   // One full frame: GROUPS groups of six samples in channel order.
   task automatic send_frame(input frame_kind_type kind);
      tx_steady = ($urandom_range(0, 3) == 0);
      for (int grp = 0; grp < GROUPS; grp++)
         for (int ch = 0; ch < CH_COUNT; ch++)
            push_sample(pick_sample(kind, ch, grp));
      frames_sent++;
   endtask

   // Holds samples back until every report is in and the converter has drained.
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_reports != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Back-to-back register writes, optionally to the unused index as well.
   task automatic apply_settings(input logic [REF_W-1:0] ref_v,
                                 input logic [RANGE_W-1:0] motor_v,
                                 input logic [RANGE_W-1:0] battery_v,
                                 input bit poke_unused);
      csr_we    <= 1'b1;
      csr_index <= REG_REF_MV;
      csr_wdata <= CSR_DATA_W'(ref_v);
      @(posedge clock);
      csr_index <= REG_HALL_MOTOR;
      csr_wdata <= CSR_DATA_W'(motor_v);
      @(posedge clock);
      csr_index <= REG_HALL_BATTERY;
      csr_wdata <= CSR_DATA_W'(battery_v);
      @(posedge clock);
      if (poke_unused) begin
         csr_index <= REG_UNUSED;
         csr_wdata <= CSR_DATA_W'($urandom_range(0, 8191));
         @(posedge clock);
      end
      csr_we  <= 1'b0;
      cur_ref  = ref_v;
      settings_applied++;
   endtask

   // Stimulus and verdict.
   initial begin
      logic [REF_W-1:0]   ref_v;
      logic [RANGE_W-1:0] motor_v;
      logic [RANGE_W-1:0] battery_v;
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.sample <= '0;
      csr_we         <= 1'b0;
      csr_index      <= REG_REF_MV;
      csr_wdata      <= '0;
      cur_ref         = REF_MV_RESET;
      samples_sent    = 0;
      frames_sent     = 0;
      settings_applied = 0;
      tx_steady       = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Register values out of reset with an uneven per-channel frame.
      send_frame(FRAME_STAIR);

      // Largest reference and hall ranges drive the hall currents into saturation.
      settle();
      apply_settings(13'd8191, 6'd63, 6'd63, 1'b1);
      send_frame(FRAME_FULL);

      // Zero reference and zero hall ranges.
      settle();
      apply_settings(13'd0, 6'd0, 6'd0, 1'b0);
      send_frame(FRAME_MIXED);

      // Low end of the usual ranges, samples around the hall midpoint.
      settle();
      apply_settings(13'd1000, 6'd1, 6'd1, 1'b1);
      send_frame(FRAME_NEAR_MID);

      // Random settings with a mixed frame.
      settle();
      ref_v     = ($urandom_range(0, 3) == 0) ? REF_W'($urandom_range(0, 8191))
                                              : REF_W'($urandom_range(1000, 5000));
      motor_v   = ($urandom_range(0, 3) == 0) ? RANGE_W'($urandom_range(0, 63))
                                              : RANGE_W'($urandom_range(1, 50));
      battery_v = ($urandom_range(0, 3) == 0) ? RANGE_W'($urandom_range(0, 63))
                                              : RANGE_W'($urandom_range(1, 50));
      apply_settings(ref_v, motor_v, battery_v, 1'($urandom_range(0, 1)));
      send_frame(FRAME_MIXED);

      settle();
      $display("Sent %0d samples in %0d frames under %0d register settings; %0d reports checked.",
               samples_sent, frames_sent, settings_applied + 1, reports_checked);
      $display("Settings spanned zero and full-scale reference and hall ranges, with stalls on both sides.");
      if (fail_count == 0 && pending_reports == 0) begin
         $display("PASS adc_frame_average_current_monitor_unit");
      end else begin
         $display("FAIL adc_frame_average_current_monitor_unit");
      end
      $finish;
   end

endmodule
